FILE: rtl/fcws_pkg.sv
// ----------------------------------------------------------------------------
// fcws_pkg
// Shared constants and types for the frame cadence window statistics core.
// ----------------------------------------------------------------------------
`default_nettype none

package fcws_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS   = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL      = 2'd1;

    // register reset values
    localparam int unsigned RESET_TARGET_US  = 16667;
    localparam int unsigned RESET_INTERVAL   = 60;

    // stutter threshold: max(FLOOR, floor(target * NUM / DEN))
    localparam int unsigned STUTTER_FLOOR_US = 20000;
    localparam int unsigned OUTLIER_NUM      = 135;
    localparam int unsigned OUTLIER_DEN      = 100;
    // headroom bits for the constant products (NUM and DEN are below 256)
    localparam int unsigned OUTLIER_BITS     = 8;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/fcws_front.sv
// ----------------------------------------------------------------------------
// fcws_front
// Holds configuration, classifies each sample and accumulates the window.
// Pushes a snapshot of the finished window to the summary queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fcws_front #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned COUNT_BITS  = 16,
    parameter int unsigned CFG_BITS    = 24,
    parameter int unsigned SNAP_BITS   = 3 * COUNT_BITS + 3 * SAMPLE_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [fcws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]                cfg_data,
    input  wire logic                               in_accept,
    input  wire logic [SAMPLE_BITS-1:0]             sample,
    output logic                                    snap_push,
    output logic [SNAP_BITS-1:0]                    snap_data
);

    localparam int unsigned TOTAL_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int unsigned PROD_BITS  = SAMPLE_BITS + fcws_pkg::OUTLIER_BITS;

    logic [SAMPLE_BITS-1:0] target_reg;
    logic [COUNT_BITS-1:0]  interval_reg;
    logic [COUNT_BITS-1:0]  count_reg,   count_next;
    logic [TOTAL_BITS-1:0]  total_reg,   total_next;
    logic [SAMPLE_BITS-1:0] min_reg,     min_next;
    logic [SAMPLE_BITS-1:0] max_reg,     max_next;
    logic [COUNT_BITS-1:0]  stut_reg,    stut_next;

    logic                   saturated;
    logic                   first;
    logic                   stutter;
    logic                   emit;
    logic [PROD_BITS-1:0]   sample_scaled;
    logic [PROD_BITS-1:0]   target_scaled;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= SAMPLE_BITS'(fcws_pkg::RESET_TARGET_US);
            interval_reg <= COUNT_BITS'(fcws_pkg::RESET_INTERVAL);
        end else if (cfg_we) begin
            case (cfg_index)
                fcws_pkg::CFG_TARGET_PERIOD: target_reg   <= cfg_data[SAMPLE_BITS-1:0];
                fcws_pkg::CFG_INTERVAL:      interval_reg <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // floor(t*NUM/DEN) <= s  <=>  t*NUM <= s*DEN + (DEN-1)
    assign sample_scaled = PROD_BITS'(sample) * PROD_BITS'(fcws_pkg::OUTLIER_DEN)
                         + PROD_BITS'(fcws_pkg::OUTLIER_DEN - 1);
    assign target_scaled = PROD_BITS'(target_reg) * PROD_BITS'(fcws_pkg::OUTLIER_NUM);

    assign saturated = &count_reg;
    assign first     = (count_reg == '0);
    assign stutter   = (target_reg != '0)
                     && (sample >= SAMPLE_BITS'(fcws_pkg::STUTTER_FLOOR_US))
                     && (sample_scaled >= target_scaled);

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        stut_next  = stut_reg;
        if (!saturated) begin
            count_next = count_reg + 1'b1;
            total_next = total_reg + TOTAL_BITS'(sample);
            if (first || sample < min_reg) begin
                min_next = sample;
            end
            if (first || sample > max_reg) begin
                max_next = sample;
            end
            if (stutter) begin
                stut_next = stut_reg + 1'b1;
            end
        end
    end

    assign emit      = (interval_reg != '0) && (count_next >= interval_reg);
    assign snap_push = in_accept && emit;
    // low to high: count, stutters, total, min, max
    assign snap_data = {max_next, min_next, total_next, stut_next, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            stut_reg  <= '0;
        end else if (in_accept) begin
            if (emit) begin
                count_reg <= '0;
                total_reg <= '0;
                min_reg   <= '0;
                max_reg   <= '0;
                stut_reg  <= '0;
            end else begin
                count_reg <= count_next;
                total_reg <= total_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                stut_reg  <= stut_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fcws_queue.sv
// ----------------------------------------------------------------------------
// fcws_queue
// Two-entry queue of window snapshots between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fcws_queue #(
    parameter int unsigned WIDTH = 120
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fcws_back.sv
// ----------------------------------------------------------------------------
// fcws_back
// Takes a snapshot, divides total by count one quotient bit per cycle and
// holds the summary in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fcws_back #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned COUNT_BITS  = 16,
    parameter int unsigned SNAP_BITS   = 3 * COUNT_BITS + 3 * SAMPLE_BITS,
    parameter int unsigned OUT_BITS    = 104
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 snap_empty,
    input  wire logic [SNAP_BITS-1:0] snap_data,
    output logic                      snap_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_BITS-1:0]       m_tdata
);

    localparam int unsigned TOTAL_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int unsigned STEP_BITS  = $clog2(TOTAL_BITS);

    fcws_pkg::back_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  stut_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [TOTAL_BITS-1:0]  dvd_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [OUT_BITS-1:0]    out_reg;

    logic [COUNT_BITS:0]    rem_shift;
    logic                   q_bit;
    logic [COUNT_BITS:0]    rem_sub;
    logic                   last_step;
    logic [SAMPLE_BITS-1:0] average;

    assign rem_shift = {rem_reg, dvd_reg[TOTAL_BITS-1]};
    assign q_bit     = (rem_shift >= {1'b0, count_reg});
    assign rem_sub   = rem_shift - {1'b0, count_reg};
    assign last_step = (step_reg == STEP_BITS'(TOTAL_BITS - 1));
    assign average   = (count_reg == '0) ? '0
                     : {dvd_reg[SAMPLE_BITS-2:0], q_bit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcws_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        snap_pop   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            fcws_pkg::BK_IDLE: begin
                if (!snap_empty) begin
                    snap_pop   = 1'b1;
                    state_next = fcws_pkg::BK_DIV;
                end
            end
            fcws_pkg::BK_DIV: begin
                if (last_step) begin
                    state_next = fcws_pkg::BK_OUT;
                end
            end
            fcws_pkg::BK_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = fcws_pkg::BK_IDLE;
                end
            end
            default: state_next = fcws_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (snap_pop) begin
            count_reg <= snap_data[COUNT_BITS-1:0];
            stut_reg  <= snap_data[2*COUNT_BITS-1:COUNT_BITS];
            dvd_reg   <= snap_data[2*COUNT_BITS+TOTAL_BITS-1:2*COUNT_BITS];
            min_reg   <= snap_data[2*COUNT_BITS+TOTAL_BITS+SAMPLE_BITS-1:
                                   2*COUNT_BITS+TOTAL_BITS];
            max_reg   <= snap_data[SNAP_BITS-1:2*COUNT_BITS+TOTAL_BITS+SAMPLE_BITS];
            rem_reg   <= '0;
            step_reg  <= '0;
        end else if (state_reg == fcws_pkg::BK_DIV) begin
            rem_reg  <= q_bit ? rem_sub[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
            dvd_reg  <= {dvd_reg[TOTAL_BITS-2:0], q_bit};
            step_reg <= step_reg + 1'b1;
            if (last_step) begin
                out_reg <= OUT_BITS'({max_reg, min_reg, average, stut_reg, count_reg});
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

FILE: rtl/frame_cadence_window_stats_core.sv
// ----------------------------------------------------------------------------
// frame_cadence_window_stats_core
// Windowed count, stutter count, mean, minimum and maximum of frame intervals.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: sample_us
//  m_      | out | m_tvalid/m_tready  | m_tdata: count, stutters, avg, min, max
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Samples are taken one per cycle while the queue has room; accumulation updates in that cycle.
//  A finished window is queued (two entries). The back end loads a snapshot,
//  divides total by count one bit per cycle and holds the result until it is
//  handed off; it takes the next snapshot only after that hand-off.
//  s_tready drops only while the queue is full. cfg_ready is always high.
//  Reset is synchronous, active low; all windows clear and registers reload.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_cadence_window_stats_core #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [SAMPLE_BITS-1:0] sample_us, rest zero
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // sample_count, stutter_count, average_us, min_us, max_us, zero pad
    output logic [((2*COUNT_BITS+3*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fcws_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [((SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS)-1:0] cfg_data
);

    localparam int unsigned CFG_BITS  = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;
    localparam int unsigned SNAP_BITS = 3 * COUNT_BITS + 3 * SAMPLE_BITS;
    localparam int unsigned OUT_BITS  = ((2 * COUNT_BITS + 3 * SAMPLE_BITS + 7) / 8) * 8;

    logic                 in_accept;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic [SNAP_BITS-1:0] q_wdata;
    logic [SNAP_BITS-1:0] q_rdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    fcws_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .CFG_BITS    (CFG_BITS),
        .SNAP_BITS   (SNAP_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .snap_push (q_push),
        .snap_data (q_wdata)
    );

    fcws_queue #(
        .WIDTH (SNAP_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    fcws_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SNAP_BITS   (SNAP_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_empty (q_empty),
        .snap_data  (q_rdata),
        .snap_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("summary queue popped while empty");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (!q_full || q_pop))
        else $error("summary queue pushed while full");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> !q_empty)
        else $error("pushed summary missing from queue");

    a_out_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> !m_tvalid)
        else $error("result shown while divide in progress");

endmodule

`default_nettype wire
